>>> rtl/salfu_pkg.sv
// Shared types and constants for the LFU cache tag directory.
`default_nettype none

package salfu_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int COUNT_WIDTH  = 16;
    localparam int TAG_W        = 32;
    localparam int WORD_W       = 32;
    localparam int PADDR_W      = 4;

    localparam logic [2:0] SET_BITS_RST   = 3'd2;
    localparam logic [2:0] BLOCK_BITS_RST = 3'd2;
    localparam logic [5:0] TAG_BITS_RST   = 6'd28;
    localparam logic [3:0] WAYS_USED_RST  = 4'd2;

    typedef enum logic [1:0] {
        REG_SET_BITS,
        REG_BLOCK_BITS,
        REG_TAG_BITS,
        REG_WAYS_USED
    } reg_idx_t;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [2:0] block_bits;
        logic [5:0] tag_bits;
        logic [3:0] ways_used;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

endpackage

`default_nettype wire

>>> rtl/salfu_cfg.sv
// APB register file holding the address split and way count settings.
`default_nettype none

module salfu_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [salfu_pkg::PADDR_W-1:0]    paddr,
    input  logic [salfu_pkg::WORD_W-1:0]     pwdata,
    output logic [salfu_pkg::WORD_W-1:0]     prdata,
    output logic                             pready,
    output salfu_pkg::cfg_t                  cfg
);

    salfu_pkg::cfg_t     cfg_reg;
    salfu_pkg::cfg_t     cfg_next;
    salfu_pkg::reg_idx_t idx;
    logic                wr_en;

    assign idx    = salfu_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                salfu_pkg::REG_SET_BITS:   cfg_next.set_bits   = pwdata[2:0];
                salfu_pkg::REG_BLOCK_BITS: cfg_next.block_bits = pwdata[2:0];
                salfu_pkg::REG_TAG_BITS:   cfg_next.tag_bits   = pwdata[5:0];
                salfu_pkg::REG_WAYS_USED:  cfg_next.ways_used  = pwdata[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            salfu_pkg::REG_SET_BITS:   prdata = 32'(cfg_reg.set_bits);
            salfu_pkg::REG_BLOCK_BITS: prdata = 32'(cfg_reg.block_bits);
            salfu_pkg::REG_TAG_BITS:   prdata = 32'(cfg_reg.tag_bits);
            salfu_pkg::REG_WAYS_USED:  prdata = 32'(cfg_reg.ways_used);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits   <= salfu_pkg::SET_BITS_RST;
            cfg_reg.block_bits <= salfu_pkg::BLOCK_BITS_RST;
            cfg_reg.tag_bits   <= salfu_pkg::TAG_BITS_RST;
            cfg_reg.ways_used  <= salfu_pkg::WAYS_USED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/salfu_mem.sv
// Set memory: one row per set, all ways of the set side by side.
`default_nettype none

module salfu_mem
#(
    parameter int AW     = 6,
    parameter int DATA_W = 392
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [0:(1 << AW)-1];
    logic [DATA_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/salfu_lookup.sv
// Tag compare, LFU victim pick and count update over one set row.
`default_nettype none

module salfu_lookup
#(
    parameter int MAX_WAYS    = 8,
    parameter int COUNT_WIDTH = 16,
    localparam int LINE_W     = 1 + salfu_pkg::TAG_W + COUNT_WIDTH,
    localparam int ROW_W      = MAX_WAYS * LINE_W,
    localparam int WC_W       = $clog2(MAX_WAYS + 1),
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
)
(
    input  logic [ROW_W-1:0]              row_i,
    input  logic [salfu_pkg::TAG_W-1:0]   tag_i,
    input  logic [WC_W-1:0]               ways_i,
    output logic                          hit_o,
    output logic [WAY_W-1:0]              way_o,
    output logic                          vic_valid_o,
    output logic [salfu_pkg::TAG_W-1:0]   vic_tag_o,
    output logic [ROW_W-1:0]              row_o
);

    // line layout: {valid, tag, count}
    logic                          hit;
    logic [WAY_W-1:0]              hit_way;
    logic [WAY_W-1:0]              min_way;
    logic [WAY_W-1:0]              sel;
    logic [COUNT_WIDTH-1:0]        best;
    logic [LINE_W-1:0]             line;
    logic [COUNT_WIDTH-1:0]        cnt;
    logic [COUNT_WIDTH-1:0]        cnt_new;

    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!hit && (WC_W'(w) < ways_i) && row_i[w*LINE_W + LINE_W - 1]
                && (row_i[w*LINE_W + COUNT_WIDTH +: salfu_pkg::TAG_W] == tag_i))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // first way with strictly lowest count
        best    = row_i[0 +: COUNT_WIDTH];
        min_way = '0;
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if ((WC_W'(w) < ways_i) && (row_i[w*LINE_W +: COUNT_WIDTH] < best))
            begin
                best    = row_i[w*LINE_W +: COUNT_WIDTH];
                min_way = WAY_W'(w);
            end
        end

        sel     = hit ? hit_way : min_way;
        line    = row_i[sel*LINE_W +: LINE_W];
        cnt     = line[COUNT_WIDTH-1:0];
        cnt_new = (&cnt) ? cnt : cnt + 1'b1;

        row_o = row_i;
        row_o[sel*LINE_W +: LINE_W] = {1'b1, tag_i, cnt_new};

        hit_o       = hit;
        way_o       = sel;
        vic_valid_o = hit ? 1'b0 : line[LINE_W-1];
        vic_tag_o   = hit ? '0 : line[COUNT_WIDTH +: salfu_pkg::TAG_W];
    end

endmodule

`default_nettype wire

>>> rtl/set_assoc_cache_lfu_lookup_top.sv
// Top level of the LFU set-associative cache tag directory.
//
// channel   direction  handshake                     payload
// config    in/out     psel/penable/pwrite/pready    paddr, pwdata, prdata
// lookup    in         start && !busy                address
// result    out        done (one cycle, no stall)    hit, way, set_sel, tag_value,
//                                                    victim_was_valid, victim_tag, fill_base
//
// After reset a clearing pass zeroes every row of the set memory, busy high.
// Each word is read first as its set row from the single-port-read memory, then in ST_LOOK
// all ways are compared, the victim is picked and the row is written back.
// done is high in the cycle after that write; a new word may be taken in that same cycle.
// Results cannot be held off by the receiver.
`default_nettype none

module set_assoc_cache_lfu_lookup_top
#(
    parameter int MAX_SET_BITS = salfu_pkg::MAX_SET_BITS,
    parameter int MAX_WAYS     = salfu_pkg::MAX_WAYS,
    parameter int COUNT_WIDTH  = salfu_pkg::COUNT_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [salfu_pkg::PADDR_W-1:0]  paddr,
    input  logic [salfu_pkg::WORD_W-1:0]   pwdata,
    output logic [salfu_pkg::WORD_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    address,
    output logic                           done,
    output logic                           hit,
    output logic [2:0]                     way,
    output logic [5:0]                     set_sel,
    output logic [31:0]                    tag_value,
    output logic                           victim_was_valid,
    output logic [31:0]                    victim_tag,
    output logic [31:0]                    fill_base
);

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SH_W   = $clog2(MAX_SET_BITS + 8);
    localparam int WC_W   = $clog2(MAX_WAYS + 1);
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LINE_W = 1 + salfu_pkg::TAG_W + COUNT_WIDTH;
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    salfu_pkg::cfg_t   cfg;
    salfu_pkg::state_t state_reg;
    salfu_pkg::state_t state_next;

    logic [SET_W-1:0]  clr_reg;
    logic [SET_W-1:0]  clr_next;

    // address split for the incoming word
    logic [SH_W-1:0]   s_eff;
    logic [SH_W-1:0]   b_eff;
    logic [SH_W-1:0]   sh;
    logic [5:0]        t_eff;
    logic [SET_W:0]    set_one;
    logic [SET_W-1:0]  set_mask;
    logic [31:0]       addr_b;
    logic [32:0]       tag_mask;
    logic [SET_W-1:0]  set_next;
    logic [31:0]       tag_next;
    logic [31:0]       fill_next;
    logic [WC_W-1:0]   ways_next;

    logic [SET_W-1:0]  set_reg;
    logic [31:0]       tag_reg;
    logic [31:0]       fill_reg;
    logic [WC_W-1:0]   ways_reg;

    logic              accept;
    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]  mem_rdata;

    logic              lk_hit;
    logic [WAY_W-1:0]  lk_way;
    logic              lk_vic_valid;
    logic [31:0]       lk_vic_tag;
    logic [ROW_W-1:0]  lk_row;

    logic              done_reg;
    logic              done_next;
    logic              hit_reg;
    logic [2:0]        way_reg;
    logic [5:0]        set_sel_reg;
    logic [31:0]       tag_value_reg;
    logic              vic_valid_reg;
    logic [31:0]       vic_tag_reg;
    logic [31:0]       fill_base_reg;

    salfu_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy   = (state_reg != salfu_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        s_eff    = (32'(cfg.set_bits) > MAX_SET_BITS) ? SH_W'(MAX_SET_BITS)
                                                      : SH_W'(cfg.set_bits);
        b_eff    = SH_W'(cfg.block_bits);
        sh       = s_eff + b_eff;
        t_eff    = (cfg.tag_bits > 6'd32) ? 6'd32 : cfg.tag_bits;
        set_one  = (SET_W+1)'(1) << s_eff;
        set_mask = SET_W'(set_one - 1'b1);
        addr_b   = address >> b_eff;
        set_next = addr_b[SET_W-1:0] & set_mask;
        tag_mask = (33'd1 << t_eff) - 33'd1;
        tag_next = (address >> sh) & tag_mask[31:0];
        fill_next = address & ~((32'd1 << b_eff) - 32'd1);
        if (cfg.ways_used == 4'd0)
        begin
            ways_next = WC_W'(1);
        end
        else if (32'(cfg.ways_used) > MAX_WAYS)
        begin
            ways_next = WC_W'(MAX_WAYS);
        end
        else
        begin
            ways_next = WC_W'(cfg.ways_used);
        end
    end

    salfu_mem
    #(
        .AW     (SET_W),
        .DATA_W (ROW_W)
    )
    u_mem
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (set_next),
        .rd_data (mem_rdata)
    );

    salfu_lookup
    #(
        .MAX_WAYS    (MAX_WAYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_lookup
    (
        .row_i       (mem_rdata),
        .tag_i       (tag_reg),
        .ways_i      (ways_reg),
        .hit_o       (lk_hit),
        .way_o       (lk_way),
        .vic_valid_o (lk_vic_valid),
        .vic_tag_o   (lk_vic_tag),
        .row_o       (lk_row)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = set_reg;
        mem_wdata  = lk_row;
        done_next  = 1'b0;
        case (state_reg)
            salfu_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = salfu_pkg::ST_IDLE;
                end
            end
            salfu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = salfu_pkg::ST_LOOK;
                end
            end
            salfu_pkg::ST_LOOK:
            begin
                mem_we     = 1'b1;
                done_next  = 1'b1;
                state_next = salfu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = salfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salfu_pkg::ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg  <= set_next;
            tag_reg  <= tag_next;
            fill_reg <= fill_next;
            ways_reg <= ways_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == salfu_pkg::ST_LOOK)
        begin
            hit_reg       <= lk_hit;
            way_reg       <= 3'(lk_way);
            set_sel_reg   <= 6'(set_reg);
            tag_value_reg <= tag_reg;
            vic_valid_reg <= lk_vic_valid;
            vic_tag_reg   <= lk_vic_tag;
            fill_base_reg <= lk_hit ? 32'd0 : fill_reg;
        end
    end

    assign done             = done_reg;
    assign hit              = hit_reg;
    assign way              = way_reg;
    assign set_sel          = set_sel_reg;
    assign tag_value        = tag_value_reg;
    assign victim_was_valid = vic_valid_reg;
    assign victim_tag       = vic_tag_reg;
    assign fill_base        = fill_base_reg;

endmodule

`default_nettype wire

>>> rtl/salfu_checker.sv
// Port-level checks for the LFU tag directory, bound to the top level.
`default_nettype none

module salfu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic        victim_was_valid,
    input logic [31:0] victim_tag,
    input logic [31:0] fill_base,
    input logic        pready
);

    // every result word follows an accepted word, after its row read and its ST_LOOK state
    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("done without a lookup two cycles earlier");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!victim_was_valid && victim_tag == 32'd0 && fill_base == 32'd0))
        else $error("victim fields set on a hit");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind set_assoc_cache_lfu_lookup_top salfu_checker u_salfu_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .hit              (hit),
    .victim_was_valid (victim_was_valid),
    .victim_tag       (victim_tag),
    .fill_base        (fill_base),
    .pready           (pready)
);

`default_nettype wire
